// ----- design/assert_macros.svh -----
// Assertion macros shared by the frame acceptance RTL.
// Needs a clock named clk and a synchronous reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tcfarm_pkg.sv -----
// Types, codes and helpers for the TC frame acceptance (FARM-1 style) block.
// No dependencies; used by tcfarm_classify and tc_frame_acceptance_farm_unit.
`timescale 1ns / 1ps

package tcfarm_pkg;

  localparam logic [7:0] CMD_UNLOCK     = 8'h00;
  localparam logic [7:0] CMD_SET_VR     = 8'h82;
  localparam logic [7:0] SET_VR_QUAL    = 8'h00;
  localparam logic [9:0] SET_VR_MIN_LEN = 10'd3;
  localparam logic [1:0] COP_IN_EFFECT  = 2'b01;

  localparam logic [3:0] ST_IN_SEQ      = 4'd0;
  localparam logic [3:0] ST_BYPASS      = 4'd1;
  localparam logic [3:0] ST_UNLOCK      = 4'd2;
  localparam logic [3:0] ST_SET_VR      = 4'd3;
  localparam logic [3:0] ST_WRONG_VC    = 4'd4;
  localparam logic [3:0] ST_EMPTY_CTRL  = 4'd5;
  localparam logic [3:0] ST_UNSUPPORTED = 4'd6;
  localparam logic [3:0] ST_DUPLICATE   = 4'd7;
  localparam logic [3:0] ST_AHEAD       = 4'd8;
  localparam logic [3:0] ST_LOCKOUT     = 4'd9;

  localparam logic REG_OWN_VCID    = 1'b0;
  localparam logic REG_WINDOW_SIZE = 1'b1;

  localparam logic [5:0] OWN_VCID_RESET    = 6'd0;
  localparam logic [7:0] WINDOW_SIZE_RESET = 8'd10;

  typedef struct packed {
    logic [5:0] vcid;
    logic       bypass;
    logic       control;
    logic [7:0] fsn;
    logic [9:0] byte_count;
    logic [7:0] cmd_byte0;
    logic [7:0] cmd_byte1;
    logic [7:0] cmd_byte2;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] clcw;
  } result_t;

  typedef struct packed {
    logic [7:0] expected_seq;
    logic       lockout;
    logic       retransmit;
  } farm_state_t;

  typedef struct packed {
    logic [5:0] own_vcid;
    logic [7:0] window_size;
  } farm_cfg_t;

  function automatic logic [31:0] make_clcw(farm_cfg_t cfg, farm_state_t st);
    logic [31:0] w;
    w          = '0;
    w[25:24]   = COP_IN_EFFECT;
    w[23:18]   = cfg.own_vcid;
    w[13]      = st.lockout;
    w[11]      = st.retransmit;
    w[7:0]     = st.expected_seq;
    return w;
  endfunction

endpackage

// ----- design/tcfarm_classify.sv -----
// Acceptance decision for one TC frame header against the FARM state.
// Depends on tcfarm_pkg; purely combinational, used by the top level.
`timescale 1ns / 1ps

module tcfarm_classify (
  input  tcfarm_pkg::item_t       item,
  input  tcfarm_pkg::farm_state_t state,
  input  tcfarm_pkg::farm_cfg_t   cfg,
  output tcfarm_pkg::farm_state_t state_next,
  output tcfarm_pkg::result_t     result
);

  logic [6:0] half;
  logic [7:0] behind;
  logic [7:0] ahead;
  logic [3:0] status;

  assign half   = cfg.window_size[7:1];
  assign behind = state.expected_seq - item.fsn;
  assign ahead  = item.fsn - state.expected_seq;

  always_comb begin
    state_next = state;
    if (item.vcid != cfg.own_vcid) begin
      status = tcfarm_pkg::ST_WRONG_VC;
    end else if (item.control) begin
      if (item.byte_count == '0) begin
        status = tcfarm_pkg::ST_EMPTY_CTRL;
      end else if (item.cmd_byte0 == tcfarm_pkg::CMD_UNLOCK) begin
        state_next.lockout    = 1'b0;
        state_next.retransmit = 1'b0;
        status                = tcfarm_pkg::ST_UNLOCK;
      end else if (item.byte_count >= tcfarm_pkg::SET_VR_MIN_LEN &&
                   item.cmd_byte0 == tcfarm_pkg::CMD_SET_VR &&
                   item.cmd_byte1 == tcfarm_pkg::SET_VR_QUAL) begin
        state_next.expected_seq = item.cmd_byte2;
        state_next.retransmit   = 1'b0;
        status                  = tcfarm_pkg::ST_SET_VR;
      end else begin
        status = tcfarm_pkg::ST_UNSUPPORTED;
      end
    end else if (item.bypass) begin
      status = tcfarm_pkg::ST_BYPASS;
    end else if (item.fsn == state.expected_seq) begin
      state_next.expected_seq = state.expected_seq + 8'd1;
      state_next.retransmit   = 1'b0;
      status                  = tcfarm_pkg::ST_IN_SEQ;
    end else if (behind < {1'b0, half}) begin
      status = tcfarm_pkg::ST_DUPLICATE;
    end else if (ahead < {1'b0, half}) begin
      state_next.retransmit = 1'b1;
      status                = tcfarm_pkg::ST_AHEAD;
    end else begin
      state_next.lockout = 1'b1;
      status             = tcfarm_pkg::ST_LOCKOUT;
    end
  end

  assign result.status = status;
  assign result.clcw   = tcfarm_pkg::make_clcw(cfg, state_next);

endmodule

// ----- design/tc_frame_acceptance_farm_unit.sv -----
// Top level of the TC frame acceptance block: input register, decision, result register.
// Depends on tcfarm_pkg, tcfarm_classify and assert_macros.svh.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+---------------------------------
//   item     | item_valid / item_stall        | item   (tcfarm_pkg::item_t)
//   result   | result_valid / result_stall    | result (tcfarm_pkg::result_t)
//   cfg      | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// One item per cycle while result_stall is low, through the input and result registers.
// The FARM state updates as an item moves from the input register to the result register.
// A stalled result holds the result register; the input register then fills and item_stall rises.
// Reset (rst, synchronous) empties both registers, clears V(R) and the flags, and
// loads the configuration reset values. Configuration writes are always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tc_frame_acceptance_farm_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  tcfarm_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output tcfarm_pkg::result_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  logic                    held_valid;
  tcfarm_pkg::item_t       held;
  tcfarm_pkg::farm_state_t state;
  tcfarm_pkg::farm_state_t state_next;
  tcfarm_pkg::farm_cfg_t   cfg;
  tcfarm_pkg::result_t     result_next;
  logic                    out_free;
  logic                    advance;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = held_valid && out_free;
  assign item_stall = held_valid && !out_free;
  assign cfg_ready  = 1'b1;

  tcfarm_classify u_classify (
    .item       (held),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_vcid    <= tcfarm_pkg::OWN_VCID_RESET;
      cfg.window_size <= tcfarm_pkg::WINDOW_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcfarm_pkg::REG_OWN_VCID:    cfg.own_vcid    <= cfg_data[5:0];
        tcfarm_pkg::REG_WINDOW_SIZE: cfg.window_size <= cfg_data;
        default: ;
      endcase
    end
  end

  `ASSERT_NEXT(a_state_hold, !advance, state == $past(state), "FARM state moved without a transfer")
  `ASSERT_NEXT(a_wrong_vc_no_change, advance && result_next.status == tcfarm_pkg::ST_WRONG_VC, state == $past(state), "wrong VC frame changed FARM state")
  `ASSERT_NEXT(a_in_seq_step, advance && result_next.status == tcfarm_pkg::ST_IN_SEQ, state.expected_seq == $past(state.expected_seq) + 8'd1, "V(R) did not advance on in-sequence frame")
  `ASSERT_NEXT(a_clcw_tracks_state, advance, result.clcw[7:0] == state.expected_seq && result.clcw[13] == state.lockout, "CLCW does not match FARM state")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for tc_frame_acceptance_farm_unit: directed and random frame headers
// checked against an in-bench FARM-1 acceptance predictor. Depends on tcfarm_pkg and tc_frame_acceptance_farm_unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 3;
  localparam logic [7:0] CMD_UNKNOWN = 8'h55;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  tcfarm_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  tcfarm_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = tcfarm_pkg::REG_OWN_VCID;
  logic [7:0] cfg_data = '0;

  // predictor state and configuration
  logic [7:0] vr = '0;
  logic lock_flag = 1'b0;
  logic retx_flag = 1'b0;
  logic [5:0] cfg_vcid = tcfarm_pkg::OWN_VCID_RESET;
  logic [7:0] cfg_window = tcfarm_pkg::WINDOW_SIZE_RESET;

  tcfarm_pkg::item_t pending_frames[$];
  tcfarm_pkg::result_t awaited_results[$];
  logic [7:0] gen_vr = '0;
  int send_idle_pct = 38;
  int recv_idle_pct = 56;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  int errors = 0;

  tc_frame_acceptance_farm_unit uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] classify_sequenced(logic [7:0] fsn);
    logic [7:0] half;
    logic [7:0] behind;
    logic [7:0] ahead;
    half = cfg_window >> 1;
    behind = vr - fsn;
    ahead = fsn - vr;
    if (fsn == vr) begin
      vr = vr + 8'd1;
      retx_flag = 1'b0;
      return tcfarm_pkg::ST_IN_SEQ;
    end
    if (behind < half) return tcfarm_pkg::ST_DUPLICATE;
    if (ahead < half) begin
      retx_flag = 1'b1;
      return tcfarm_pkg::ST_AHEAD;
    end
    lock_flag = 1'b1;
    return tcfarm_pkg::ST_LOCKOUT;
  endfunction

  function automatic logic [3:0] run_command(tcfarm_pkg::item_t f);
    if (f.byte_count == '0) return tcfarm_pkg::ST_EMPTY_CTRL;
    if (f.cmd_byte0 == tcfarm_pkg::CMD_UNLOCK) begin
      lock_flag = 1'b0;
      retx_flag = 1'b0;
      return tcfarm_pkg::ST_UNLOCK;
    end
    if (f.byte_count >= tcfarm_pkg::SET_VR_MIN_LEN && f.cmd_byte0 == tcfarm_pkg::CMD_SET_VR &&
        f.cmd_byte1 == tcfarm_pkg::SET_VR_QUAL) begin
      vr = f.cmd_byte2;
      retx_flag = 1'b0;
      return tcfarm_pkg::ST_SET_VR;
    end
    return tcfarm_pkg::ST_UNSUPPORTED;
  endfunction

  function automatic void accept_frame(tcfarm_pkg::item_t f);
    tcfarm_pkg::result_t r;
    if (f.vcid != cfg_vcid) r.status = tcfarm_pkg::ST_WRONG_VC;
    else if (f.control) r.status = run_command(f);
    else if (f.bypass) r.status = tcfarm_pkg::ST_BYPASS;
    else r.status = classify_sequenced(f.fsn);
    r.clcw = {6'b0, tcfarm_pkg::COP_IN_EFFECT, cfg_vcid, 4'b0, lock_flag, 1'b0, retx_flag,
              3'b0, vr};
    awaited_results.push_back(r);
  endfunction

  function automatic tcfarm_pkg::item_t hdr(logic [5:0] vcid, logic bypass, logic control,
                                            logic [7:0] fsn, logic [9:0] len, logic [7:0] b0,
                                            logic [7:0] b1, logic [7:0] b2);
    tcfarm_pkg::item_t f;
    f.vcid = vcid;
    f.bypass = bypass;
    f.control = control;
    f.fsn = fsn;
    f.byte_count = len;
    f.cmd_byte0 = b0;
    f.cmd_byte1 = b1;
    f.cmd_byte2 = b2;
    return f;
  endfunction

  function automatic tcfarm_pkg::item_t random_frame();
    tcfarm_pkg::item_t f;
    int pick;
    f = hdr(cfg_vcid, 1'b0, 1'b0, 8'($urandom_range(255)), 10'($urandom_range(1023)),
            8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 50) begin
      f.fsn = gen_vr;
      gen_vr = gen_vr + 8'd1;
    end else if (pick < 62) begin
      f.fsn = gen_vr - 8'($urandom_range(1, 70));
    end else if (pick < 74) begin
      f.fsn = gen_vr + 8'($urandom_range(1, 70));
    end else if (pick < 79) begin
      f.fsn = f.fsn;
    end else if (pick < 85) begin
      f.vcid = 6'($urandom_range(63));
      f.bypass = 1'($urandom_range(1));
      f.control = 1'($urandom_range(1));
    end else if (pick < 90) begin
      f.bypass = 1'b1;
    end else begin
      f.control = 1'b1;
      f.bypass = 1'($urandom_range(1));
      case ($urandom_range(3))
        0: begin
          f.byte_count = 10'($urandom_range(1, 1023));
          f.cmd_byte0 = tcfarm_pkg::CMD_UNLOCK;
        end
        1: begin
          f.byte_count = 10'($urandom_range(tcfarm_pkg::SET_VR_MIN_LEN, 1023));
          f.cmd_byte0 = tcfarm_pkg::CMD_SET_VR;
          f.cmd_byte1 = tcfarm_pkg::SET_VR_QUAL;
          gen_vr = f.cmd_byte2;
        end
        2: begin
          f.byte_count = 10'($urandom_range(3));
          f.cmd_byte0 = ($urandom_range(1) != 0) ? tcfarm_pkg::CMD_SET_VR : f.cmd_byte0;
          f.cmd_byte1 = tcfarm_pkg::SET_VR_QUAL;
        end
        default: begin
          f.byte_count = f.byte_count;
        end
      endcase
    end
    return f;
  endfunction

  // frame sender
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) accept_frame(item);
      if (!item_valid || !item_stall) begin
        if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_frames.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      result_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (holds_served < holds_requested) begin
      result_stall <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    tcfarm_pkg::result_t exp_r;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d clcw %08h", result.status, result.clcw);
          errors++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (result.status !== exp_r.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_r.status, result.status);
            errors++;
          end
          if (result.clcw !== exp_r.clcw) begin
            $error("clcw mismatch: expected %08h, actual %08h", exp_r.clcw, result.clcw);
            errors++;
          end
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic drain();
    while (pending_frames.size() != 0 || item_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == tcfarm_pkg::REG_OWN_VCID) cfg_vcid = data[5:0];
    else cfg_window = data;
  endtask

  task automatic run_phase(input logic [5:0] vcid, input logic [7:0] window, input int count,
                           input int s_pct, input int r_pct, input bit hold);
    drain();
    write_reg(tcfarm_pkg::REG_OWN_VCID, {2'b00, vcid});
    write_reg(tcfarm_pkg::REG_WINDOW_SIZE, window);
    @(negedge clk);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    gen_vr = vr;
    if (hold) holds_requested++;
    repeat (count) pending_frames.push_back(random_frame());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    pending_frames.push_back(hdr(6'd63, 1'b0, 1'b0, 8'd0, 10'd0, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'd0, 10'd0, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'd1, 10'd5, 8'd1, 8'd2, 8'd3));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'd0, 10'd5, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'd5, 10'd5, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'd2, 10'd5, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'd128, 10'd5, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'd3, 10'd5, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b1, 1'b0, 8'd255, 10'd1023, 8'd255, 8'd255, 8'd255));
    pending_frames.push_back(hdr(6'd0, 1'b1, 1'b1, 8'd0, 10'd1, tcfarm_pkg::CMD_UNLOCK,
                                 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b1, 8'd0, 10'd0, tcfarm_pkg::CMD_SET_VR,
                                 tcfarm_pkg::SET_VR_QUAL, 8'd9));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b1, 8'd0, 10'd3, tcfarm_pkg::CMD_SET_VR,
                                 tcfarm_pkg::SET_VR_QUAL, 8'd255));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'd255, 10'd0, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b1, 8'd0, 10'd2, tcfarm_pkg::CMD_SET_VR,
                                 tcfarm_pkg::SET_VR_QUAL, 8'd7));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b1, 8'd0, 10'd3, tcfarm_pkg::CMD_SET_VR,
                                 8'd1, 8'd7));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b1, 8'd0, 10'd5, CMD_UNKNOWN, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b1, 8'd0, 10'd1023, tcfarm_pkg::CMD_SET_VR,
                                 tcfarm_pkg::SET_VR_QUAL, 8'hAA));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'hA6, 10'd5, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'hA5, 10'd5, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'hAE, 10'd5, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b0, 8'hAF, 10'd5, 8'd0, 8'd0, 8'd0));
    pending_frames.push_back(hdr(6'd0, 1'b0, 1'b1, 8'd0, 10'd1023, tcfarm_pkg::CMD_UNLOCK,
                                 8'd255, 8'd255));
    pending_frames.push_back(hdr(6'd1, 1'b0, 1'b1, 8'd0, 10'd1, tcfarm_pkg::CMD_UNLOCK,
                                 8'd0, 8'd0));

    run_phase(6'd0, 8'd10, 270, 38, 56, 1'b0);
    run_phase(6'd63, 8'd4, 270, 38, 56, 1'b1);
    run_phase(6'd17, 8'd128, 270, 38, 56, 1'b0);
    run_phase(6'd5, 8'd0, 270, 56, 38, 1'b0);
    run_phase(6'd42, 8'd255, 270, 56, 38, 1'b1);
    run_phase(6'd0, 8'd1, 270, 0, 0, 1'b0);
    run_phase(6'd30, 8'd16, 270, 0, 0, 1'b0);
    drain();

    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      errors++;
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/tcfarm_pkg.sv
design/tcfarm_classify.sv
design/tc_frame_acceptance_farm_unit.sv
dv/tb_top.sv
